[rtl/tcp_client_connection_step_core_macros.svh]
// assertion macros for the tcp client connection step core
// expects clk and rst_n in the scope of use
`ifndef TCP_CLIENT_CONNECTION_STEP_CORE_MACROS_SVH
`define TCP_CLIENT_CONNECTION_STEP_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define TCPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define TCPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tcpc_pkg.sv]
// types and constants of the tcp client connection step core
// no dependencies
package tcpc_pkg;

  typedef enum logic [1:0] {
    ST_CLOSED  = 2'd0,
    ST_SYN     = 2'd1,
    ST_EST     = 2'd2,
    ST_CLOSING = 2'd3
  } conn_state_t;

  typedef enum logic [2:0] {
    KIND_CONNECT = 3'd0,
    KIND_SEND    = 3'd1,
    KIND_FRAME   = 3'd2,
    KIND_RECEIVE = 3'd3,
    KIND_CLOSE   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_EST   = 2'd1,
    STAT_LINK_FAIL = 2'd2
  } status_t;

  localparam logic [7:0]  FL_FIN = 8'h01;
  localparam logic [7:0]  FL_SYN = 8'h02;
  localparam logic [7:0]  FL_PSH = 8'h08;
  localparam logic [7:0]  FL_ACK = 8'h10;

  localparam logic [15:0] HDR_BYTES   = 16'd40;
  localparam logic [15:0] FRAME_CAP   = 16'd1460;
  localparam logic [10:0] HDR_LEN_11  = 11'd40;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  conn_state;
    logic [10:0] delivered_len;
    logic        seg_valid;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [15:0] seg_src_port;
    logic [15:0] seg_dst_port;
    logic [31:0] seg_dst_ip;
    logic [10:0] seg_total_len;
  } res_t;

endpackage

[rtl/tcp_client_connection_step_core.sv]
// flow: each accepted request is held in the request register, then moves into the result register
// throughput: one request per cycle unless out_stall holds; connection state updates in the same cycle the
// request moves into the result register, so the next request sees it at once
// reset: synchronous active-low rst_n; connection closed, seq/ack/peer/own port zero,
// next port FIRST_PORT, both register stages empty
`include "tcp_client_connection_step_core_macros.svh"

module tcp_client_connection_step_core
  import tcpc_pkg::*;
#(
  parameter int MAX_SEGMENT = 1024,
  parameter int FIRST_PORT  = 40000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_remote_addr,
  input  logic [15:0] in_remote_port_in,
  input  logic [15:0] in_length,
  input  logic        in_link_ok,
  input  logic [7:0]  in_rx_flags,
  input  logic [31:0] in_rx_seq,
  input  logic [15:0] in_rx_total_len,
  input  logic [10:0] in_max_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [1:0]  out_conn_state,
  output logic [10:0] out_delivered_len,
  output logic        out_seg_valid,
  output logic [7:0]  out_seg_flags,
  output logic [31:0] out_seg_seq,
  output logic [31:0] out_seg_ack,
  output logic [15:0] out_seg_src_port,
  output logic [15:0] out_seg_dst_port,
  output logic [31:0] out_seg_dst_ip,
  output logic [10:0] out_seg_total_len
);

  localparam logic [15:0] MAX_SEG_16 = 16'(MAX_SEGMENT);
  localparam logic [15:0] FIRST_PORT_16 = 16'(FIRST_PORT);

  // request register
  logic        item_valid_r;
  logic [2:0]  kind_r;
  logic [31:0] remote_addr_r;
  logic [15:0] remote_port_r;
  logic [15:0] length_r;
  logic        link_ok_r;
  logic [7:0]  rx_flags_r;
  logic [31:0] rx_seq_r;
  logic [15:0] rx_total_len_r;
  logic [10:0] max_len_r;

  // connection state
  conn_state_t link_state_r, link_state_nxt;
  logic [31:0] send_seq_r, send_seq_nxt;
  logic [31:0] recv_ack_r, recv_ack_nxt;
  logic [31:0] peer_addr_r, peer_addr_nxt;
  logic [15:0] peer_port_r, peer_port_nxt;
  logic [15:0] own_port_r, own_port_nxt;
  logic [15:0] next_port_r, next_port_nxt;

  // result register
  logic        out_valid_r;
  res_t        res_r, res_nxt;

  logic        in_accept;
  logic        adv;
  logic        hdr_ok;
  logic        hs_hit;
  logic        fin_set;
  logic [10:0] send_len;
  logic [15:0] payload;
  logic        deliver_ok;

  assign adv       = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = item_valid_r && !adv;
  assign in_accept = in_valid && !in_stall;

  assign hdr_ok   = length_r >= HDR_BYTES;
  assign hs_hit   = (link_state_r == ST_SYN) && ((rx_flags_r & (FL_SYN | FL_ACK)) != 8'd0);
  assign fin_set  = (rx_flags_r & FL_FIN) != 8'd0;
  assign send_len = (length_r > MAX_SEG_16) ? MAX_SEG_16[10:0] : length_r[10:0];
  assign payload  = rx_total_len_r - HDR_BYTES;
  assign deliver_ok = (rx_total_len_r >= HDR_BYTES) && (payload != 16'd0)
                      && (payload <= {5'd0, max_len_r}) && (payload <= FRAME_CAP);

  // next connection state
  always_comb begin
    link_state_nxt = link_state_r;
    send_seq_nxt   = send_seq_r;
    recv_ack_nxt   = recv_ack_r;
    peer_addr_nxt  = peer_addr_r;
    peer_port_nxt  = peer_port_r;
    own_port_nxt   = own_port_r;
    next_port_nxt  = next_port_r;
    case (kind_r)
      KIND_CONNECT: begin
        peer_addr_nxt  = remote_addr_r;
        peer_port_nxt  = remote_port_r;
        own_port_nxt   = next_port_r;
        next_port_nxt  = next_port_r + 16'd1;
        send_seq_nxt   = 32'd1;
        recv_ack_nxt   = 32'd0;
        link_state_nxt = link_ok_r ? ST_SYN : ST_CLOSED;
      end
      KIND_SEND: begin
        if (link_state_r == ST_EST && link_ok_r) begin
          send_seq_nxt = send_seq_r + {21'd0, send_len};
        end
      end
      KIND_FRAME: begin
        if (hdr_ok) begin
          if (hs_hit) begin
            recv_ack_nxt   = rx_seq_r + 32'd1;
            send_seq_nxt   = send_seq_r + 32'd1;
            link_state_nxt = ST_EST;
          end else if (fin_set) begin
            link_state_nxt = ST_CLOSING;
          end
        end
      end
      KIND_RECEIVE: begin
        if (link_state_r == ST_EST && length_r != 16'd0) begin
          if (hdr_ok && fin_set) begin
            link_state_nxt = ST_CLOSING;
          end
          if (deliver_ok) begin
            recv_ack_nxt = recv_ack_r + {16'd0, payload};
          end
        end
      end
      KIND_CLOSE: begin
        link_state_nxt = ST_CLOSED;
      end
      default: begin
      end
    endcase
  end

  // result fields
  always_comb begin
    res_nxt = '0;
    res_nxt.status     = STAT_OK;
    res_nxt.conn_state = link_state_nxt;
    case (kind_r)
      KIND_CONNECT: begin
        res_nxt.seg_valid     = 1'b1;
        res_nxt.seg_flags     = FL_SYN;
        res_nxt.seg_seq       = 32'd1;
        res_nxt.seg_ack       = 32'd0;
        res_nxt.seg_src_port  = next_port_r;
        res_nxt.seg_dst_port  = remote_port_r;
        res_nxt.seg_dst_ip    = remote_addr_r;
        res_nxt.seg_total_len = HDR_LEN_11;
        if (!link_ok_r) begin
          res_nxt.status = STAT_LINK_FAIL;
        end
      end
      KIND_SEND: begin
        if (link_state_r != ST_EST) begin
          res_nxt.status = STAT_NOT_EST;
        end else begin
          res_nxt.seg_valid     = 1'b1;
          res_nxt.seg_flags     = FL_ACK | FL_PSH;
          res_nxt.seg_seq       = send_seq_r;
          res_nxt.seg_ack       = recv_ack_r;
          res_nxt.seg_src_port  = own_port_r;
          res_nxt.seg_dst_port  = peer_port_r;
          res_nxt.seg_dst_ip    = peer_addr_r;
          res_nxt.seg_total_len = HDR_LEN_11 + send_len;
          if (!link_ok_r) begin
            res_nxt.status = STAT_LINK_FAIL;
          end
        end
      end
      KIND_FRAME: begin
        if (hdr_ok && hs_hit) begin
          res_nxt.seg_valid     = 1'b1;
          res_nxt.seg_flags     = FL_ACK;
          res_nxt.seg_seq       = send_seq_r + 32'd1;
          res_nxt.seg_ack       = rx_seq_r + 32'd1;
          res_nxt.seg_src_port  = own_port_r;
          res_nxt.seg_dst_port  = peer_port_r;
          res_nxt.seg_dst_ip    = peer_addr_r;
          res_nxt.seg_total_len = HDR_LEN_11;
        end
      end
      KIND_RECEIVE: begin
        if (link_state_r != ST_EST) begin
          res_nxt.status = STAT_NOT_EST;
        end else if (length_r != 16'd0 && deliver_ok) begin
          res_nxt.delivered_len = payload[10:0];
        end
      end
      KIND_CLOSE: begin
        if (link_state_r == ST_EST) begin
          res_nxt.seg_valid     = 1'b1;
          res_nxt.seg_flags     = FL_FIN | FL_ACK;
          res_nxt.seg_seq       = send_seq_r;
          res_nxt.seg_ack       = recv_ack_r;
          res_nxt.seg_src_port  = own_port_r;
          res_nxt.seg_dst_port  = peer_port_r;
          res_nxt.seg_dst_ip    = peer_addr_r;
          res_nxt.seg_total_len = HDR_LEN_11;
        end
      end
      default: begin
      end
    endcase
  end

  // control and connection state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      link_state_r <= ST_CLOSED;
      send_seq_r   <= 32'd0;
      recv_ack_r   <= 32'd0;
      peer_addr_r  <= 32'd0;
      peer_port_r  <= 16'd0;
      own_port_r   <= 16'd0;
      next_port_r  <= FIRST_PORT_16;
    end else begin
      if (in_accept) begin
        item_valid_r <= 1'b1;
      end else if (adv) begin
        item_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r  <= 1'b1;
        link_state_r <= link_state_nxt;
        send_seq_r   <= send_seq_nxt;
        recv_ack_r   <= recv_ack_nxt;
        peer_addr_r  <= peer_addr_nxt;
        peer_port_r  <= peer_port_nxt;
        own_port_r   <= own_port_nxt;
        next_port_r  <= next_port_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r         <= in_kind;
      remote_addr_r  <= in_remote_addr;
      remote_port_r  <= in_remote_port_in;
      length_r       <= in_length;
      link_ok_r      <= in_link_ok;
      rx_flags_r     <= in_rx_flags;
      rx_seq_r       <= in_rx_seq;
      rx_total_len_r <= in_rx_total_len;
      max_len_r      <= in_max_len;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_conn_state    = res_r.conn_state;
  assign out_delivered_len = res_r.delivered_len;
  assign out_seg_valid     = res_r.seg_valid;
  assign out_seg_flags     = res_r.seg_flags;
  assign out_seg_seq       = res_r.seg_seq;
  assign out_seg_ack       = res_r.seg_ack;
  assign out_seg_src_port  = res_r.seg_src_port;
  assign out_seg_dst_port  = res_r.seg_dst_port;
  assign out_seg_dst_ip    = res_r.seg_dst_ip;
  assign out_seg_total_len = res_r.seg_total_len;

  `TCPC_ASSERT_NOW(a_no_seg_fields, out_valid_r && !res_r.seg_valid, res_r.seg_flags == 8'd0 && res_r.seg_total_len == 11'd0 && res_r.seg_dst_ip == 32'd0, "segment fields set without segment")
  `TCPC_ASSERT_NOW(a_seg_len_min, out_valid_r && res_r.seg_valid, res_r.seg_total_len >= HDR_LEN_11, "segment shorter than header")
  `TCPC_ASSERT_NOW(a_not_est_quiet, out_valid_r && res_r.status == STAT_NOT_EST, !res_r.seg_valid && res_r.delivered_len == 11'd0, "activity on not-established request")
  `TCPC_ASSERT_NEXT(a_stall_holds, out_valid_r && out_stall, out_valid_r && $stable(res_r), "result changed while stalled")

endmodule
